FILE: rtl/bste_pkg.sv
// Shared constants and control types for the bounding sphere test-and-expand block.
`timescale 1ns / 1ps

package bste_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int RADIUS_BITS    = 17;
    localparam int OP_BITS        = 3;
    localparam int CFG_IDX_BITS   = 2;

    localparam logic [RADIUS_BITS-1:0] RADIUS_MAX = {RADIUS_BITS{1'b1}};

    localparam logic [OP_BITS-1:0] OP_SET_RADIUS = 3'd0;
    localparam logic [OP_BITS-1:0] OP_INTERSECTS = 3'd1;
    localparam logic [OP_BITS-1:0] OP_ENVELOPS   = 3'd2;
    localparam logic [OP_BITS-1:0] OP_CONTAINS   = 3'd3;
    localparam logic [OP_BITS-1:0] OP_GROW_POINT = 3'd4;
    localparam logic [OP_BITS-1:0] OP_GROW_SPHR  = 3'd5;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Z = 2'd2;

    typedef struct packed {
        logic clr;
        logic mul_en;
        logic acc_en;
    } t_mac_ctl;

    typedef struct packed {
        logic load;
        logic step;
    } t_sqrt_ctl;

endpackage

FILE: rtl/bste_in_if.sv
// Input word channel: opcode, position and other radius.
`timescale 1ns / 1ps

interface bste_in_if #(
    parameter int COORD_BITS = bste_pkg::COORD_BITS_DEF
) ();
    logic                                valid;
    logic                                ready;
    logic [bste_pkg::OP_BITS-1:0]        opcode;
    logic signed [COORD_BITS-1:0]        pos_x;
    logic signed [COORD_BITS-1:0]        pos_y;
    logic signed [COORD_BITS-1:0]        pos_z;
    logic [bste_pkg::RADIUS_BITS-1:0]    other_radius;

    modport source (output valid, opcode, pos_x, pos_y, pos_z, other_radius, input ready);
    modport sink   (input valid, opcode, pos_x, pos_y, pos_z, other_radius, output ready);
endinterface

FILE: rtl/bste_out_if.sv
// Result word channel: hit flag, current radius and saturation flag.
`timescale 1ns / 1ps

interface bste_out_if ();
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic [bste_pkg::RADIUS_BITS-1:0]    current_radius;
    logic                                saturated;

    modport source (output valid, hit, current_radius, saturated, input ready);
    modport sink   (input valid, hit, current_radius, saturated, output ready);
endinterface

FILE: rtl/bounding_sphere_test_and_expand.sv
// Top level: sequencer, center and radius registers, output register.
// Sequence: set radius and unused opcodes go straight to the result; tests run
//   five squaring/compare steps on the shared multiplier; expansions (bar a grow-point
//   word already inside) then step the square root unit, one root bit per cycle.
// Throughput: one word at a time; the input is ready again the cycle after the result
//   is loaded into the output register, which holds it until taken.
// Reset (synchronous, active low): center and radius cleared, channels idle.
`timescale 1ns / 1ps

module bounding_sphere_test_and_expand #(
    parameter int COORD_BITS = bste_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    bste_in_if.sink                               i_in,
    bste_out_if.source                            o_out,
    input  logic                                  i_cfg_we,
    input  logic [bste_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [COORD_BITS-1:0]                 i_cfg_data
);
    localparam int RB = bste_pkg::RADIUS_BITS;
    localparam int CB = COORD_BITS;
    localparam int OW = (CB + 1 > RB + 1) ? CB + 1 : RB + 1;
    localparam int AW = 2 * OW;
    localparam int DW = 2 * CB + 2;
    localparam int NR = DW / 2;
    localparam int CW = $clog2(NR + 1);
    localparam int NW = ((NR + 1 > RB) ? NR + 1 : RB) + 1;

    localparam logic [CW-1:0] STEP_X   = CW'(0);
    localparam logic [CW-1:0] STEP_Y   = CW'(1);
    localparam logic [CW-1:0] STEP_Z   = CW'(2);
    localparam logic [CW-1:0] STEP_THR = CW'(3);
    localparam logic [CW-1:0] STEP_CMP = CW'(4);
    localparam logic [CW-1:0] SQRT_END = CW'(NR - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_SQRT = 5'b00100,
        S_FIN  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                         r_state, n_state;
    logic [CW-1:0]                  r_cnt, n_cnt;
    logic [CB-1:0]                  r_cx, r_cy, r_cz;
    logic [RB-1:0]                  r_rad;
    logic                           r_ovalid;
    logic                           r_ohit;
    logic [RB-1:0]                  r_orad;
    logic                           r_osat;

    logic [bste_pkg::OP_BITS-1:0]   r_op, n_op;
    logic [RB-1:0]                  r_r, n_r;
    logic [CB:0]                    r_ax, n_ax, r_ay, n_ay, r_az, n_az;
    logic                           r_hit, n_hit;
    logic                           r_set, n_set;
    logic                           r_grow, n_grow;
    logic [NW-1:0]                  r_need, n_need;

    logic signed [CB:0]             w_dx, w_dy, w_dz;
    logic [RB:0]                    w_thr;
    logic [OW-1:0]                  w_opd;
    logic [AW-1:0]                  w_prod, w_acc;
    logic [NR:0]                    w_root;
    logic                           w_le;
    logic                           w_load;
    logic                           w_grow_now;
    logic                           w_sat;
    logic [RB-1:0]                  w_new_rad;
    bste_pkg::t_mac_ctl             w_mac;
    bste_pkg::t_sqrt_ctl            w_sq;

    // Differences to the center, one bit wider, then magnitudes.
    assign w_dx = signed'({i_in.pos_x[CB-1], i_in.pos_x}) - signed'({r_cx[CB-1], r_cx});
    assign w_dy = signed'({i_in.pos_y[CB-1], i_in.pos_y}) - signed'({r_cy[CB-1], r_cy});
    assign w_dz = signed'({i_in.pos_z[CB-1], i_in.pos_z}) - signed'({r_cz[CB-1], r_cz});

    always_comb begin
        case (r_op)
            bste_pkg::OP_INTERSECTS: w_thr = {1'b0, r_rad} + {1'b0, r_r};
            bste_pkg::OP_ENVELOPS:   w_thr = {1'b0, r_rad} - {1'b0, r_r};
            default:                 w_thr = {1'b0, r_rad};
        endcase
    end

    always_comb begin
        case (r_cnt)
            STEP_X:   w_opd = OW'(r_ax);
            STEP_Y:   w_opd = OW'(r_ay);
            STEP_Z:   w_opd = OW'(r_az);
            default:  w_opd = OW'(w_thr);
        endcase
    end

    assign w_le = (w_acc <= w_prod);

    bste_sqacc #(.OW(OW)) u_sqacc (
        .i_clk  (i_clk),
        .i_ctl  (w_mac),
        .i_opd  (w_opd),
        .o_prod (w_prod),
        .o_acc  (w_acc)
    );

    bste_isqrt #(.DW(DW)) u_isqrt (
        .i_clk  (i_clk),
        .i_ctl  (w_sq),
        .i_rad  (w_acc[DW-1:0]),
        .o_root (w_root)
    );

    // Radius update applied when the result is loaded.
    assign w_grow_now = r_grow && (r_need > NW'(r_rad));
    assign w_sat      = w_grow_now && (r_need > NW'(bste_pkg::RADIUS_MAX));
    always_comb begin
        if (r_set) begin
            w_new_rad = r_r;
        end else if (w_sat) begin
            w_new_rad = bste_pkg::RADIUS_MAX;
        end else if (w_grow_now) begin
            w_new_rad = r_need[RB-1:0];
        end else begin
            w_new_rad = r_rad;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_op    = r_op;
        n_r     = r_r;
        n_ax    = r_ax;
        n_ay    = r_ay;
        n_az    = r_az;
        n_hit   = r_hit;
        n_set   = r_set;
        n_grow  = r_grow;
        n_need  = r_need;
        w_mac   = '0;
        w_sq    = '0;
        w_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op   = i_in.opcode;
                    n_r    = i_in.other_radius;
                    n_ax   = w_dx[CB] ? (CB+1)'(-w_dx) : (CB+1)'(w_dx);
                    n_ay   = w_dy[CB] ? (CB+1)'(-w_dy) : (CB+1)'(w_dy);
                    n_az   = w_dz[CB] ? (CB+1)'(-w_dz) : (CB+1)'(w_dz);
                    n_hit  = 1'b0;
                    n_set  = (i_in.opcode == bste_pkg::OP_SET_RADIUS);
                    n_grow = 1'b0;
                    n_cnt  = '0;
                    w_mac.clr = 1'b1;
                    if (i_in.opcode == bste_pkg::OP_INTERSECTS ||
                        i_in.opcode == bste_pkg::OP_ENVELOPS   ||
                        i_in.opcode == bste_pkg::OP_CONTAINS   ||
                        i_in.opcode == bste_pkg::OP_GROW_POINT ||
                        i_in.opcode == bste_pkg::OP_GROW_SPHR) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MUL: begin
                w_mac.mul_en = (r_cnt <= STEP_THR);
                w_mac.acc_en = (r_cnt >= STEP_Y) && (r_cnt <= STEP_THR);
                n_cnt        = r_cnt + CW'(1);
                if (r_cnt == STEP_CMP) begin
                    // Sum of squares is final; product holds the squared threshold.
                    n_cnt     = '0;
                    w_sq.load = 1'b1;
                    n_state   = S_DONE;
                    case (r_op)
                        bste_pkg::OP_INTERSECTS: n_hit = w_le;
                        bste_pkg::OP_ENVELOPS:   n_hit = w_le && (r_rad >= r_r);
                        bste_pkg::OP_CONTAINS:   n_hit = w_le;
                        bste_pkg::OP_GROW_POINT: begin
                            if (!w_le) begin
                                n_grow  = 1'b1;
                                n_state = S_SQRT;
                            end
                        end
                        bste_pkg::OP_GROW_SPHR: begin
                            n_grow  = 1'b1;
                            n_state = S_SQRT;
                        end
                        default: n_hit = 1'b0;
                    endcase
                end
            end
            S_SQRT: begin
                w_sq.step = 1'b1;
                n_cnt     = r_cnt + CW'(1);
                if (r_cnt == SQRT_END) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_need  = NW'(w_root) +
                          ((r_op == bste_pkg::OP_GROW_SPHR) ? NW'(r_r) : NW'(0));
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
            r_rad    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bste_pkg::CFG_CENTER_X: r_cx <= i_cfg_data;
                    bste_pkg::CFG_CENTER_Y: r_cy <= i_cfg_data;
                    bste_pkg::CFG_CENTER_Z: r_cz <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_load) begin
                r_rad    <= w_new_rad;
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_r    <= n_r;
        r_ax   <= n_ax;
        r_ay   <= n_ay;
        r_az   <= n_az;
        r_hit  <= n_hit;
        r_set  <= n_set;
        r_grow <= n_grow;
        r_need <= n_need;
        if (w_load) begin
            r_ohit <= r_hit;
            r_orad <= w_new_rad;
            r_osat <= w_sat;
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_ovalid;
    assign o_out.hit            = r_ohit;
    assign o_out.current_radius = r_orad;
    assign o_out.saturated      = r_osat;

    a_sat_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_osat) |-> (r_orad == bste_pkg::RADIUS_MAX))
        else $error("saturated result without maximum radius");

    a_hit_only_tests: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_hit) |-> (r_op == bste_pkg::OP_INTERSECTS ||
                               r_op == bste_pkg::OP_ENVELOPS ||
                               r_op == bste_pkg::OP_CONTAINS))
        else $error("hit raised for a non-test opcode");

    a_grow_no_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_op == bste_pkg::OP_GROW_POINT || r_op == bste_pkg::OP_GROW_SPHR))
        |=> (r_rad >= $past(r_rad)))
        else $error("expansion reduced the radius");

    a_root_is_ceil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |->
        (((AW+4)'(w_root) * (AW+4)'(w_root)) >= (AW+4)'(w_acc)) &&
        ((w_root == '0) ||
         (((AW+4)'(w_root) - (AW+4)'(1)) * ((AW+4)'(w_root) - (AW+4)'(1)) < (AW+4)'(w_acc))))
        else $error("square root unit gave a wrong ceiling root");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != S_IDLE))
        else $error("accepted word did not start the sequencer");
endmodule

FILE: rtl/bste_sqacc.sv
// Shared squaring unit with a registered product and a sum-of-squares accumulator.
`timescale 1ns / 1ps

module bste_sqacc #(
    parameter int OW = 18
) (
    input  logic                 i_clk,
    input  bste_pkg::t_mac_ctl   i_ctl,
    input  logic [OW-1:0]        i_opd,
    output logic [2*OW-1:0]      o_prod,
    output logic [2*OW-1:0]      o_acc
);
    logic [2*OW-1:0] r_prod;
    logic [2*OW-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_opd * i_opd;
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;
endmodule

FILE: rtl/bste_isqrt.sv
// Restoring square root, one root bit per cycle while stepped, with ceiling correction on the output.
`timescale 1ns / 1ps

module bste_isqrt #(
    parameter int DW = 34
) (
    input  logic                 i_clk,
    input  bste_pkg::t_sqrt_ctl  i_ctl,
    input  logic [DW-1:0]        i_rad,
    output logic [DW/2:0]        o_root
);
    localparam int N  = DW / 2;
    localparam int RW = N + 3;

    logic [DW-1:0] r_rad;
    logic [RW-1:0] r_rem;
    logic [N-1:0]  r_root;
    logic [RW-1:0] w_rem_sh;
    logic [RW-1:0] w_trial;
    logic          w_ge;

    // Bring down the next two radicand bits and try a one in the next root bit.
    assign w_rem_sh = {r_rem[RW-3:0], r_rad[DW-1 -: 2]};
    assign w_trial  = {{(RW-N-2){1'b0}}, r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_ctl.step) begin
            r_rad <= {r_rad[DW-3:0], 2'b00};
            if (w_ge) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[N-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[N-2:0], 1'b0};
            end
        end
    end

    // Round up when the floor root leaves a remainder.
    assign o_root = {1'b0, r_root} + (N+1)'(r_rem != '0);
endmodule

FILE: test/tb_bounding_sphere_test_and_expand.sv
// Self-checking testbench for the bounding sphere test-and-expand block.
`timescale 1ns / 1ps

module tb_bounding_sphere_test_and_expand;

    localparam int COORD_W = bste_pkg::COORD_BITS_DEF;
    localparam int OP_W    = bste_pkg::OP_BITS;
    localparam int RAD_W   = bste_pkg::RADIUS_BITS;

    localparam logic [OP_W-1:0]                   OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0]                   OP_SPARE_7 = 3'd7;
    localparam logic [bste_pkg::CFG_IDX_BITS-1:0] CFG_SPARE  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [RAD_W-1:0]   r;
    } t_sphere_word;

    typedef struct packed {
        logic             hit;
        logic [RAD_W-1:0] radius;
        logic             sat;
    } t_sphere_res;

    typedef struct {
        t_sphere_word w;
        bit           known;
        t_sphere_res  res;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;
    logic                              i_cfg_we;
    logic [bste_pkg::CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [COORD_W-1:0]                i_cfg_data;

    bste_in_if #(.COORD_BITS(COORD_W)) in_ch ();
    bste_out_if                        out_ch ();

    bounding_sphere_test_and_expand #(.COORD_BITS(COORD_W)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the block's center and radius
    logic signed [COORD_W-1:0] ctr_x = '0;
    logic signed [COORD_W-1:0] ctr_y = '0;
    logic signed [COORD_W-1:0] ctr_z = '0;
    logic [RAD_W-1:0]          sphere_rad = '0;

    t_sphere_res due_results[$];
    t_plan_row   directed_rows[$];
    int          mismatches = 0;
    int          src_idle_pct = 25;
    int          snk_idle_pct = 25;
    int          hold_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("tb_bounding_sphere_test_and_expand: FAIL");
        $finish;
    end

    function automatic longint unsigned dist_sq(logic signed [COORD_W-1:0] px,
                                                logic signed [COORD_W-1:0] py,
                                                logic signed [COORD_W-1:0] pz);
        longint dx, dy, dz;
        dx = longint'(px) - longint'(ctr_x);
        dy = longint'(py) - longint'(ctr_y);
        dz = longint'(pz) - longint'(ctr_z);
        return longint'(dx * dx + dy * dy + dz * dz);
    endfunction

    // Smallest n with n*n >= v
    function automatic longint unsigned root_up(longint unsigned v);
        longint unsigned root, trial;
        root = 0;
        for (int b = 20; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        if (root * root < v) root++;
        return root;
    endfunction

    function automatic t_sphere_res apply_word(t_sphere_word w);
        t_sphere_res     res;
        longint unsigned d2, need, big_r, r;
        big_r   = sphere_rad;
        r       = w.r;
        res.hit = 1'b0;
        res.sat = 1'b0;
        d2      = dist_sq(w.x, w.y, w.z);
        case (w.op)
            bste_pkg::OP_SET_RADIUS: sphere_rad = w.r;
            bste_pkg::OP_INTERSECTS: res.hit = (d2 <= (big_r + r) * (big_r + r));
            bste_pkg::OP_ENVELOPS: begin
                if (big_r >= r) res.hit = (d2 <= (big_r - r) * (big_r - r));
            end
            bste_pkg::OP_CONTAINS: res.hit = (d2 <= big_r * big_r);
            bste_pkg::OP_GROW_POINT: begin
                if (d2 > big_r * big_r) begin
                    need = root_up(d2);
                    if (need > bste_pkg::RADIUS_MAX) begin
                        need    = bste_pkg::RADIUS_MAX;
                        res.sat = 1'b1;
                    end
                    sphere_rad = need[RAD_W-1:0];
                end
            end
            bste_pkg::OP_GROW_SPHR: begin
                need = root_up(d2) + r;
                if (need > big_r) begin
                    if (need > bste_pkg::RADIUS_MAX) begin
                        need    = bste_pkg::RADIUS_MAX;
                        res.sat = 1'b1;
                    end
                    sphere_rad = need[RAD_W-1:0];
                end
            end
            default: ;
        endcase
        res.radius = sphere_rad;
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(int v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[COORD_W-1:0];
    endfunction

    // Mostly points near the center at a random scale, so tests land on both sides
    function automatic t_sphere_word random_word();
        t_sphere_word w;
        int           pick, span;
        pick = int'($urandom_range(99));
        if (pick < 6) w.op = pick[0] ? OP_SPARE_7 : OP_SPARE_6;
        else w.op = OP_W'($urandom_range(bste_pkg::OP_GROW_SPHR));
        span = 1 << $urandom_range(15, 1);
        if ($urandom_range(3) == 0) begin
            w.x = COORD_W'($urandom_range(65535));
            w.y = COORD_W'($urandom_range(65535));
            w.z = COORD_W'($urandom_range(65535));
        end else begin
            w.x = clamp_coord(int'(ctr_x) + int'($urandom_range(2 * span)) - span);
            w.y = clamp_coord(int'(ctr_y) + int'($urandom_range(2 * span)) - span);
            w.z = clamp_coord(int'(ctr_z) + int'($urandom_range(2 * span)) - span);
        end
        case ($urandom_range(3))
            0:       w.r = RAD_W'($urandom_range(bste_pkg::RADIUS_MAX));
            1:       w.r = $urandom_range(1) ? bste_pkg::RADIUS_MAX : '0;
            default: w.r = RAD_W'($urandom_range(span));
        endcase
        return w;
    endfunction

    task automatic add_row(input logic [OP_W-1:0] op, input int x, input int y,
                           input int z, input int r, input bit known, input bit hit,
                           input int rad, input bit sat);
        t_plan_row row;
        row.w.op       = op;
        row.w.x        = x[COORD_W-1:0];
        row.w.y        = y[COORD_W-1:0];
        row.w.z        = z[COORD_W-1:0];
        row.w.r        = r[RAD_W-1:0];
        row.known      = known;
        row.res.hit    = hit;
        row.res.radius = rad[RAD_W-1:0];
        row.res.sat    = sat;
        directed_rows.push_back(row);
    endtask

    // Leaves valid high after the accept; the next action in the same step decides
    task automatic send_word(input t_sphere_word w, input bit known,
                             input t_sphere_res typed);
        t_sphere_res res;
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= w.op;
        in_ch.pos_x        <= w.x;
        in_ch.pos_y        <= w.y;
        in_ch.pos_z        <= w.z;
        in_ch.other_radius <= w.r;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        res = apply_word(w);
        if (known) res = typed;
        due_results.push_back(res);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bste_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [COORD_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            bste_pkg::CFG_CENTER_X: ctr_x = val;
            bste_pkg::CFG_CENTER_Y: ctr_y = val;
            bste_pkg::CFG_CENTER_Z: ctr_z = val;
            default: ;
        endcase
    endtask

    task automatic load_center(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic [COORD_W-1:0] z, input bit poke_spare);
        write_reg(bste_pkg::CFG_CENTER_X, x);
        write_reg(bste_pkg::CFG_CENTER_Y, y);
        write_reg(bste_pkg::CFG_CENTER_Z, z);
        // An index past the last register must leave the center alone
        if (poke_spare) write_reg(CFG_SPARE, COORD_W'($urandom_range(65535)));
        i_cfg_we <= 1'b0;
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_sphere_res want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (due_results.size() == 0) begin
                $error("result word with nothing expected");
                mismatches++;
            end else begin
                want = due_results.pop_front();
                if (out_ch.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, out_ch.hit);
                    mismatches++;
                end
                if (out_ch.current_radius !== want.radius) begin
                    $error("current_radius: expected %0d, got %0d",
                           want.radius, out_ch.current_radius);
                    mismatches++;
                end
                if (out_ch.saturated !== want.sat) begin
                    $error("saturated: expected %0d, got %0d", want.sat, out_ch.saturated);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        in_ch.valid        <= 1'b0;
        in_ch.opcode       <= '0;
        in_ch.pos_x        <= '0;
        in_ch.pos_y        <= '0;
        in_ch.pos_z        <= '0;
        in_ch.other_radius <= '0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= '0;
        i_cfg_data         <= '0;
        i_rst_n            <= 1'b0;

        //      op                       x       y       z       r       known hit rad    sat
        add_row(bste_pkg::OP_CONTAINS,   0,      0,      0,      0,      1,    1,  0,      0);
        add_row(bste_pkg::OP_INTERSECTS, 32767,  32767,  32767,  131071, 0,    0,  0,      0);
        add_row(bste_pkg::OP_ENVELOPS,   0,      0,      0,      1,      1,    0,  0,      0);
        add_row(bste_pkg::OP_SET_RADIUS, 0,      0,      0,      131071, 1,    0,  131071, 0);
        add_row(bste_pkg::OP_CONTAINS,   -32768, -32768, -32768, 0,      0,    0,  0,      0);
        add_row(bste_pkg::OP_GROW_SPHR,  0,      0,      0,      131071, 1,    0,  131071, 0);
        add_row(bste_pkg::OP_SET_RADIUS, 5,      -5,     5,      0,      1,    0,  0,      0);
        add_row(bste_pkg::OP_GROW_POINT, -32768, -32768, -32768, 0,      0,    0,  0,      0);
        add_row(bste_pkg::OP_GROW_SPHR,  32767,  32767,  32767,  131071, 1,    0,  131071, 1);
        add_row(bste_pkg::OP_SET_RADIUS, 0,      0,      0,      5,      1,    0,  5,      0);
        add_row(bste_pkg::OP_ENVELOPS,   0,      0,      0,      6,      1,    0,  5,      0);
        add_row(bste_pkg::OP_ENVELOPS,   0,      0,      0,      5,      1,    1,  5,      0);
        add_row(bste_pkg::OP_ENVELOPS,   3,      0,      0,      2,      0,    0,  0,      0);
        add_row(bste_pkg::OP_INTERSECTS, 8,      0,      0,      3,      0,    0,  0,      0);
        add_row(bste_pkg::OP_INTERSECTS, 9,      0,      0,      3,      0,    0,  0,      0);
        add_row(bste_pkg::OP_CONTAINS,   3,      4,      0,      0,      0,    0,  0,      0);
        add_row(bste_pkg::OP_CONTAINS,   3,      4,      1,      0,      0,    0,  0,      0);
        add_row(OP_SPARE_6,              1,      2,      3,      77,     1,    0,  5,      0);
        add_row(OP_SPARE_7,              -1,     -1,     -1,     131071, 1,    0,  5,      0);
        add_row(bste_pkg::OP_GROW_POINT, 6,      0,      0,      0,      0,    0,  0,      0);
        add_row(bste_pkg::OP_GROW_POINT, 2,      0,      0,      0,      0,    0,  0,      0);
        add_row(bste_pkg::OP_GROW_SPHR,  0,      0,      0,      3,      0,    0,  0,      0);
        add_row(bste_pkg::OP_GROW_SPHR,  1,      1,      0,      0,      0,    0,  0,      0);
        add_row(bste_pkg::OP_GROW_SPHR,  7,      0,      0,      1,      0,    0,  0,      0);
        add_row(bste_pkg::OP_GROW_POINT, 32767,  -32768, 32767,  0,      0,    0,  0,      0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].w, directed_rows[i].known, directed_rows[i].res);

        for (int ph = 0; ph < 10; ph++) begin
            drain();
            case (ph)
                0:       load_center(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
                1:       load_center(16'h8000, 16'h8000, 16'h8000, 1'b1);
                2:       load_center(16'h7fff, 16'h8000, 16'h0000, 1'b0);
                3:       load_center(COORD_W'($urandom_range(64)),
                                     COORD_W'($urandom_range(64)),
                                     COORD_W'($urandom_range(64)), 1'b0);
                default: load_center(COORD_W'($urandom_range(65535)),
                                     COORD_W'($urandom_range(65535)),
                                     COORD_W'($urandom_range(65535)), ph == 6);
            endcase
            // Stall the output long enough for the input to back up
            if (ph == 2) hold_left = 400;
            if (ph == 5) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else begin
                src_idle_pct = 25;
                snk_idle_pct = 25;
            end
            for (int n = 0; n < 50; n++) send_word(random_word(), 1'b0, '0);
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_bounding_sphere_test_and_expand: PASS");
        end else begin
            $display("tb_bounding_sphere_test_and_expand: FAIL");
        end
        $finish;
    end

endmodule
